// ----- rtl/ddo_pkg.sv -----
// ============================================================================
// ddo_pkg: shared types and constants for the odometry unit
// Payload structs, microcode word format and program, cordic arctangent table.
// ============================================================================
`default_nettype none

package ddo_pkg;

    // ------------------------------------------------------------------ payload
    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic        [31:0] heading_out;
    } t_out_item;

    // ------------------------------------------------------------ configuration
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HEADING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN     = 3'd4;

    localparam logic [31:0] LIN_GAIN_RST = 32'd733284;
    localparam logic [31:0] ANG_GAIN_RST = 32'd1074136;

    // ------------------------------------------------------------------- cordic
    localparam int CORD_W        = 33;
    localparam int ITER_W        = 5;
    localparam int CORDIC_ITERS  = 30;
    localparam int CORDIC_FRAC   = 30;
    localparam int CORDIC_K      = 652032874;

    localparam logic [1:0] QUAD_E = 2'd0;
    localparam logic [1:0] QUAD_N = 2'd1;
    localparam logic [1:0] QUAD_W = 2'd2;
    localparam logic [1:0] QUAD_S = 2'd3;

    typedef struct packed {
        logic start;
        logic step;
    } t_cordic_ctl;

    function automatic logic [29:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            5'd24:   v = 30'h00000029;
            5'd25:   v = 30'h00000014;
            5'd26:   v = 30'h0000000A;
            5'd27:   v = 30'h00000005;
            5'd28:   v = 30'h00000003;
            5'd29:   v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------- multiply unit
    localparam int ACC_W   = 66;
    localparam int MAC_A_W = 33;
    localparam int MAC_B_W = 39;
    localparam int DIG_W   = 16;
    localparam int MAC_K_W = 2;

    typedef struct packed {
        logic load;
        logic step;
    } t_mac_ctl;

    // --------------------------------------------------------------- microcode
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CORDIC,
        OP_TRIG,
        OP_MLD_DIST,
        OP_MLD_X,
        OP_MLD_Y,
        OP_MLD_TURN,
        OP_MUL,
        OP_DIST,
        OP_XUPD,
        OP_YUPD,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_CORDIC_MORE,
        C_MUL_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] A_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] A_CORDIC   = 4'd1;
    localparam logic [PC_W-1:0] A_TRIG     = 4'd2;
    localparam logic [PC_W-1:0] A_MLD_DIST = 4'd3;
    localparam logic [PC_W-1:0] A_MUL_DIST = 4'd4;
    localparam logic [PC_W-1:0] A_DIST     = 4'd5;
    localparam logic [PC_W-1:0] A_MLD_X    = 4'd6;
    localparam logic [PC_W-1:0] A_MUL_X    = 4'd7;
    localparam logic [PC_W-1:0] A_XUPD     = 4'd8;
    localparam logic [PC_W-1:0] A_MLD_Y    = 4'd9;
    localparam logic [PC_W-1:0] A_MUL_Y    = 4'd10;
    localparam logic [PC_W-1:0] A_YUPD     = 4'd11;
    localparam logic [PC_W-1:0] A_MLD_TURN = 4'd12;
    localparam logic [PC_W-1:0] A_MUL_TURN = 4'd13;
    localparam logic [PC_W-1:0] A_OUT      = 4'd14;
    localparam logic [PC_W-1:0] A_RETURN   = 4'd15;

    // a true condition jumps to target, otherwise fall through to the next step
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            A_IDLE:     w = '{op: OP_LOAD,     cond: C_NO_IN,       target: A_IDLE};
            A_CORDIC:   w = '{op: OP_CORDIC,   cond: C_CORDIC_MORE, target: A_CORDIC};
            A_TRIG:     w = '{op: OP_TRIG,     cond: C_NEVER,       target: A_IDLE};
            A_MLD_DIST: w = '{op: OP_MLD_DIST, cond: C_NEVER,       target: A_IDLE};
            A_MUL_DIST: w = '{op: OP_MUL,      cond: C_MUL_MORE,    target: A_MUL_DIST};
            A_DIST:     w = '{op: OP_DIST,     cond: C_NEVER,       target: A_IDLE};
            A_MLD_X:    w = '{op: OP_MLD_X,    cond: C_NEVER,       target: A_IDLE};
            A_MUL_X:    w = '{op: OP_MUL,      cond: C_MUL_MORE,    target: A_MUL_X};
            A_XUPD:     w = '{op: OP_XUPD,     cond: C_NEVER,       target: A_IDLE};
            A_MLD_Y:    w = '{op: OP_MLD_Y,    cond: C_NEVER,       target: A_IDLE};
            A_MUL_Y:    w = '{op: OP_MUL,      cond: C_MUL_MORE,    target: A_MUL_Y};
            A_YUPD:     w = '{op: OP_YUPD,     cond: C_NEVER,       target: A_IDLE};
            A_MLD_TURN: w = '{op: OP_MLD_TURN, cond: C_NEVER,       target: A_IDLE};
            A_MUL_TURN: w = '{op: OP_MUL,      cond: C_MUL_MORE,    target: A_MUL_TURN};
            A_OUT:      w = '{op: OP_OUT,      cond: C_OUT_BUSY,    target: A_OUT};
            A_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,      target: A_IDLE};
            default:    w = '{op: OP_NOP,      cond: C_ALWAYS,      target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ddo_cordic.sv -----
// ============================================================================
// ddo_cordic: iterative rotation cordic
// One micro-rotation per step; folds the angle to +-45 degrees plus a quadrant.
// ============================================================================
`default_nettype none

module ddo_cordic import ddo_pkg::*; (
    input  logic                     i_clk,
    input  t_cordic_ctl              i_ctl,
    input  logic [31:0]              i_angle,
    output logic signed [CORD_W-1:0] o_x,
    output logic signed [CORD_W-1:0] o_y,
    output logic [1:0]               o_quad,
    output logic                     o_last
);

    logic signed [CORD_W-1:0] r_x, r_y, r_z;
    logic signed [CORD_W-1:0] n_x, n_y, n_z;
    logic signed [CORD_W-1:0] xs, ys, atan_w;
    logic [ITER_W-1:0]        r_i;
    logic [1:0]               r_q;
    logic [31:0]              ang_biased, ang_fold;

    always_comb begin
        ang_biased = i_angle + 32'h2000_0000;
        ang_fold   = i_angle - {ang_biased[31:30], 30'd0};
        xs         = r_x >>> r_i;
        ys         = r_y >>> r_i;
        atan_w     = $signed({{(CORD_W-30){1'b0}}, atan_lut(r_i)});
        if (!r_z[CORD_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_w;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= CORD_W'(CORDIC_K);
            r_y <= '0;
            r_z <= $signed({{(CORD_W-32){ang_fold[31]}}, ang_fold});
            r_q <= ang_biased[31:30];
            r_i <= '0;
        end else if (i_ctl.step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + 1'b1;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_quad = r_q;
    assign o_last = (r_i == ITER_W'(CORDIC_ITERS - 1));

endmodule

`default_nettype wire

// ----- rtl/ddo_mac.sv -----
// ============================================================================
// ddo_mac: digit-serial multiply-accumulate
// 16-bit digit of operand a times operand b per step, shifted into the sum.
// ============================================================================
`default_nettype none

module ddo_mac import ddo_pkg::*; (
    input  logic               i_clk,
    input  t_mac_ctl           i_ctl,
    input  logic [ACC_W-1:0]   i_acc_init,
    input  logic [MAC_A_W-1:0] i_a_init,
    input  logic [MAC_B_W-1:0] i_b_init,
    output logic [ACC_W-1:0]   o_acc,
    output logic               o_more
);

    logic [ACC_W-1:0]         r_acc;
    logic [MAC_A_W-1:0]       r_a;
    logic [MAC_B_W-1:0]       r_b;
    logic [MAC_K_W-1:0]       r_k;
    logic [DIG_W+MAC_B_W-1:0] prod;
    logic [ACC_W-1:0]         term;

    assign prod = r_a[DIG_W-1:0] * r_b;
    assign term = ACC_W'(prod) << (r_k * 6'(DIG_W));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= i_acc_init;
            r_a   <= i_a_init;
            r_b   <= i_b_init;
            r_k   <= '0;
        end else if (i_ctl.step) begin
            r_acc <= r_acc + term;
            r_a   <= r_a >> DIG_W;
            r_k   <= r_k + 1'b1;
        end
    end

    assign o_acc  = r_acc;
    // digits left beyond the one consumed this step
    assign o_more = (r_a[MAC_A_W-1:DIG_W] != '0);

endmodule

`default_nettype wire

// ----- rtl/differential_drive_odometry_unit.sv -----
// ============================================================================
// differential_drive_odometry_unit: wheel encoder dead reckoning
// Tracks a planar pose (x, y, heading) from absolute left/right encoder counts.
// ============================================================================
// Each input transfer carries absolute left and right encoder counts; the unit
// takes wrapped deltas against the previous counts, forms distance
// lin_gain*(dL-dR) (right wheel mirrored) and turn ang_gain*(dL+dR), advances
// x/y (Q16.16 m, saturating) along cosine/sine of the old heading and subtracts
// the turn from the heading (binary angle, 2^32 per circle). One result
// transfer per input transfer. With the receiver ready the sequencer runs
// 30 cordic iterations and then 13 fixed steps at the default trig
// precision (trig rounding, four multiplier loads, four 16-bit digit passes,
// distance clamp, x and y updates, result load). One more digit pass is added
// when |dL-dR| needs more than 16 bits, when the wrapped 32-bit dL+dR does,
// and when a trig magnitude is exactly one (never both cosine and sine). A
// return step follows the result load, so a new item is taken only after the
// last one is finished; a stalled receiver holds the sequencer at the result
// step. Input stall is low only when the sequencer sits at its idle step; a
// finished result waits in the output register while the next item is taken.
// Configuration writes are taken while idle; writing init_x, init_y or
// init_heading also presets the matching pose value.
`default_nettype none

module differential_drive_odometry_unit import ddo_pkg::*; #(
    parameter int TRIG_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // trig magnitude width and rounding constants follow the trig precision
    localparam int TM_W   = TRIG_BITS + 1;
    localparam int RND_SH = CORDIC_FRAC - TRIG_BITS;
    localparam logic signed [CORD_W:0] TRIG_BIAS =
        (CORD_W+1)'(1) << (CORDIC_FRAC - 1 - TRIG_BITS);
    localparam logic signed [CORD_W:0] TRIG_LIM = (CORD_W+1)'(1) << TRIG_BITS;
    localparam logic [ACC_W-1:0] DIST_BIAS = ACC_W'(1) << 15;
    localparam logic [ACC_W-1:0] STEP_BIAS = ACC_W'(1) << (TRIG_BITS - 1);

    // round cordic output to TRIG_BITS fraction bits, clamp to +-1.0
    function automatic logic signed [CORD_W:0] trig_round(
        input logic signed [CORD_W-1:0] v
    );
        logic signed [CORD_W:0] w;
        logic signed [CORD_W:0] r;
        w = $signed({v[CORD_W-1], v}) + TRIG_BIAS;
        r = w >>> RND_SH;
        if (r > TRIG_LIM) begin
            r = TRIG_LIM;
        end else if (r < -TRIG_LIM) begin
            r = -TRIG_LIM;
        end
        return r;
    endfunction

    // add or subtract the rounded step and saturate to 32-bit signed
    function automatic logic [31:0] pos_advance(
        input logic [31:0]      pos,
        input logic [ACC_W-1:0] acc,
        input logic             neg
    );
        logic signed [ACC_W:0] p;
        logic signed [ACC_W:0] st;
        logic signed [ACC_W:0] r;
        logic [31:0]           res;
        p  = $signed({{(ACC_W-31){pos[31]}}, pos});
        st = $signed({1'b0, acc >> TRIG_BITS});
        r  = neg ? (p - st) : (p + st);
        if ((&r[ACC_W:31]) || !(|r[ACC_W:31])) begin
            res = r[31:0];
        end else if (r[ACC_W]) begin
            res = 32'h8000_0000;
        end else begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

    // sequencer
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          uw;
    logic            cond_true;
    logic            in_xfer, cfg_xfer, out_busy, out_load;

    // architectural state
    logic [31:0] r_prev_left, r_prev_right;
    logic [31:0] r_pos_x, r_pos_y, r_heading;
    logic [31:0] r_lin_gain, r_ang_gain;

    // per-item scratch
    logic [MAC_A_W-1:0] r_mag;
    logic               r_dneg;
    logic [31:0]        r_sum;
    logic [MAC_B_W-1:0] r_d;
    logic [TM_W-1:0]    r_cmag, r_smag;
    logic               r_cneg, r_sneg;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // delta datapath
    logic [31:0]        in_left, in_right, dl, dr;
    logic [MAC_A_W-1:0] diff;

    // trig fold
    logic signed [CORD_W-1:0] cx, sy;
    logic signed [CORD_W:0]   c_r, s_r, c_abs, s_abs;

    // submodule links
    t_cordic_ctl              cord_ctl;
    logic signed [CORD_W-1:0] cord_x, cord_y;
    logic [1:0]               cord_q;
    logic                     cord_last;
    t_mac_ctl                 mac_ctl;
    logic [ACC_W-1:0]         mac_acc_init, mac_acc;
    logic [MAC_A_W-1:0]       mac_a_init;
    logic [MAC_B_W-1:0]       mac_b_init;
    logic                     mac_more;
    logic [31:0]              new_heading;

    // ---------------------------------------------------------------- control
    assign uw       = ucode(r_pc);
    assign in_xfer  = i_in_valid && (r_pc == A_IDLE);
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign out_busy = r_out_valid && i_out_stall;
    assign out_load = (uw.op == OP_OUT) && !out_busy;

    always_comb begin
        case (uw.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_IN:       cond_true = !in_xfer;
            C_CORDIC_MORE: cond_true = !cord_last;
            C_MUL_MORE:    cond_true = mac_more;
            C_OUT_BUSY:    cond_true = out_busy;
            default:       cond_true = 1'b0;
        endcase
        n_pc = cond_true ? uw.target : r_pc + 1'b1;
    end

    assign o_in_stall  = (r_pc != A_IDLE);
    assign o_cfg_ready = (r_pc == A_IDLE);

    // ----------------------------------------------------------- count deltas
    assign in_left  = i_in_data.left_count;
    assign in_right = i_in_data.right_count;
    assign dl       = in_left - r_prev_left;
    assign dr       = in_right - r_prev_right;
    // distance sign from the 33-bit signed difference
    assign diff     = {dl[31], dl} - {dr[31], dr};

    // --------------------------------------------------------------- cordic
    assign cord_ctl.start = in_xfer;
    assign cord_ctl.step  = (uw.op == OP_CORDIC);

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_ctl   (cord_ctl),
        .i_angle (r_heading),
        .o_x     (cord_x),
        .o_y     (cord_y),
        .o_quad  (cord_q),
        .o_last  (cord_last)
    );

    // unfold the quadrant, then round to trig precision
    always_comb begin
        case (cord_q)
            QUAD_E: begin
                cx = cord_x;
                sy = cord_y;
            end
            QUAD_N: begin
                cx = -cord_y;
                sy = cord_x;
            end
            QUAD_W: begin
                cx = -cord_x;
                sy = -cord_y;
            end
            QUAD_S: begin
                cx = cord_y;
                sy = -cord_x;
            end
            default: begin
                cx = cord_x;
                sy = cord_y;
            end
        endcase
        c_r   = trig_round(cx);
        s_r   = trig_round(sy);
        c_abs = c_r[CORD_W] ? -c_r : c_r;
        s_abs = s_r[CORD_W] ? -s_r : s_r;
    end

    // ------------------------------------------------------------ multiplier
    always_comb begin
        mac_ctl.load = 1'b0;
        mac_ctl.step = (uw.op == OP_MUL);
        mac_acc_init = '0;
        mac_a_init   = r_mag;
        mac_b_init   = MAC_B_W'(r_lin_gain);
        case (uw.op)
            OP_MLD_DIST: begin
                mac_ctl.load = 1'b1;
                mac_acc_init = DIST_BIAS;
            end
            OP_MLD_X: begin
                mac_ctl.load = 1'b1;
                mac_acc_init = STEP_BIAS;
                mac_a_init   = MAC_A_W'(r_cmag);
                mac_b_init   = r_d;
            end
            OP_MLD_Y: begin
                mac_ctl.load = 1'b1;
                mac_acc_init = STEP_BIAS;
                mac_a_init   = MAC_A_W'(r_smag);
                mac_b_init   = r_d;
            end
            OP_MLD_TURN: begin
                mac_ctl.load = 1'b1;
                mac_a_init   = MAC_A_W'(r_sum);
                mac_b_init   = MAC_B_W'(r_ang_gain);
            end
            default: begin
                mac_ctl.load = 1'b0;
            end
        endcase
    end

    ddo_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (mac_ctl),
        .i_acc_init (mac_acc_init),
        .i_a_init   (mac_a_init),
        .i_b_init   (mac_b_init),
        .o_acc      (mac_acc),
        .o_more     (mac_more)
    );

    // turn is taken modulo 2^32
    assign new_heading = r_heading - mac_acc[31:0];

    // ------------------------------------------------- state with reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= A_IDLE;
            r_out_valid  <= 1'b0;
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_heading    <= '0;
            r_lin_gain   <= LIN_GAIN_RST;
            r_ang_gain   <= ANG_GAIN_RST;
        end else begin
            r_pc <= n_pc;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (in_xfer) begin
                r_prev_left  <= in_left;
                r_prev_right <= in_right;
            end
            if (uw.op == OP_XUPD) begin
                r_pos_x <= pos_advance(r_pos_x, mac_acc, r_dneg ^ r_cneg);
            end
            if (uw.op == OP_YUPD) begin
                r_pos_y <= pos_advance(r_pos_y, mac_acc, r_dneg ^ r_sneg);
            end
            if (out_load) begin
                r_heading <= new_heading;
            end

            // init writes also preset the pose
            if (cfg_xfer) begin
                case (i_cfg_index)
                    CFG_INIT_X:       r_pos_x    <= i_cfg_data;
                    CFG_INIT_Y:       r_pos_y    <= i_cfg_data;
                    CFG_INIT_HEADING: r_heading  <= i_cfg_data;
                    CFG_LIN_GAIN:     r_lin_gain <= i_cfg_data;
                    CFG_ANG_GAIN:     r_ang_gain <= i_cfg_data;
                    default:          r_lin_gain <= r_lin_gain;
                endcase
            end
        end
    end

    // ------------------------------------------------------- per-item scratch
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mag  <= diff[MAC_A_W-1] ? (MAC_A_W'(0) - diff) : diff;
            r_dneg <= diff[MAC_A_W-1];
            r_sum  <= dl + dr;
        end
        if (uw.op == OP_TRIG) begin
            r_cmag <= TM_W'(c_abs);
            r_cneg <= c_r[CORD_W];
            r_smag <= TM_W'(s_abs);
            r_sneg <= s_r[CORD_W];
        end
        // clamp distance to 2^39-1 before the trig multiply
        if (uw.op == OP_DIST) begin
            if (|mac_acc[ACC_W-1:16+MAC_B_W]) begin
                r_d <= '1;
            end else begin
                r_d <= mac_acc[16+MAC_B_W-1:16];
            end
        end
        if (out_load) begin
            r_out.pos_x_out   <= r_pos_x;
            r_out.pos_y_out   <= r_pos_y;
            r_out.heading_out <= new_heading;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------ assertions
    // an accepted item always enters the cordic loop next
    a_start_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_pc == A_CORDIC))
        else $error("item accepted without entering the cordic loop");

    // trig rounding only after the final cordic iteration
    a_trig_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == A_TRIG) |-> ($past(r_pc) == A_CORDIC && $past(cord_last)))
        else $error("trig step reached before cordic finished");

    // a loaded result shows the updated heading
    a_out_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && o_out_data.heading_out == r_heading))
        else $error("result heading differs from pose heading");

endmodule

`default_nettype wire

// ----- sim/tb_differential_drive_odometry_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_differential_drive_odometry_unit: self-checking bench for the odometry unit
// Drives encoder samples and register writes through a queued driver, predicts
// every pose with a bit-exact software model and checks each result transfer.
// ============================================================================

module tb_differential_drive_odometry_unit;
    import ddo_pkg::*;

    localparam int TRIG_BITS = 16;

    // cordic constants of the pose predictor, q30 angle table
    localparam int          ROT_STEPS = 30;
    localparam longint      ROT_K     = 652032874;
    localparam logic [63:0] DIST_CAP  = (64'd1 << 39) - 64'd1;
    localparam bit [31:0] ATAN_Q30 [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // first index past the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 3'd7;

    localparam int MAX_REPORTS = 100;

    // one pending transfer for the driver: encoder sample or register write
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          wdata;
        t_in_item             sample;
    } t_odo_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 in_vld = 1'b0;
    t_in_item             in_data = '0;
    logic                 cfg_vld = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 out_stall = 1'b0;

    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    differential_drive_odometry_unit #(
        .TRIG_BITS (TRIG_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_vld),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_vld),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_wdata)
    );

    // ------------------------------------------------------------------ clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------- predictor state
    bit [31:0] reg_init_x, reg_init_y, reg_init_hdg, gain_lin, gain_ang;
    bit [31:0] last_left, last_right, pose_x, pose_y, pose_hdg;

    t_out_item pose_q [$];   // poses still owed by the unit, oldest first
    t_odo_cmd  cmd_q [$];    // transfers not yet presented to the unit

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errs = 0;
    int n_samples = 0;
    int n_poses = 0;
    int n_writes = 0;

    // stimulus side copy of the absolute counts
    bit [31:0] gen_left = '0;
    bit [31:0] gen_right = '0;

    // round a q30 trig value to TRIG_BITS fraction bits and clamp to +-1.0
    function automatic longint trig_round(longint v);
        longint r;
        longint lim;
        r = (v + (longint'(1) << (CORDIC_FRAC - 1 - TRIG_BITS))) >>> (CORDIC_FRAC - TRIG_BITS);
        lim = longint'(1) << TRIG_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    // cosine and sine of a binary angle: fold to +-45 deg, rotate, unfold
    task automatic heading_trig(input bit [31:0] ang, output longint c, output longint s);
        bit [31:0] shifted;
        bit [31:0] resid;
        bit [1:0]  quad;
        int        resid_s;
        longint    x, y, z, xs, ys, cx, sy;
        shifted = ang + 32'h2000_0000;
        quad = shifted[31:30];
        resid = ang - {quad, 30'b0};
        resid_s = resid;
        z = resid_s;
        x = ROT_K;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_Q30[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_Q30[i]);
            end
        end
        case (quad)
            QUAD_E: begin cx = x;  sy = y;  end
            QUAD_N: begin cx = -y; sy = x;  end
            QUAD_W: begin cx = -x; sy = -y; end
            default: begin cx = y; sy = -x; end
        endcase
        c = trig_round(cx);
        s = trig_round(sy);
    endtask

    // move one axis by distance times trig factor, saturating to 32 bits
    function automatic bit [31:0] move_axis(bit [31:0] pos, bit [63:0] span, bit back,
                                            longint t);
        bit [63:0] tmag;
        bit [63:0] stride;
        bit        neg;
        int        pos_s;
        longint    r;
        tmag = (t < 0) ? -t : t;
        stride = (span * tmag + (64'd1 << (TRIG_BITS - 1))) >> TRIG_BITS;
        neg = back ^ (t < 0);
        pos_s = pos;
        r = pos_s;
        r = neg ? r - longint'(stride) : r + longint'(stride);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // dead reckoning for one encoder sample, queues the pose it must produce
    task automatic predict_pose(input t_in_item smp);
        bit [31:0] l, r, ul, ur, turn;
        int        dl_s, dr_s;
        longint    diff, c, s;
        bit [63:0] mag, span;
        t_out_item pose;
        l = smp.left_count;
        r = smp.right_count;
        ul = l - last_left;
        ur = r - last_right;
        dl_s = ul;
        dr_s = ur;
        diff = longint'(dl_s) - longint'(dr_s);
        mag = (diff < 0) ? -diff : diff;
        span = (mag * {32'b0, gain_lin} + 64'h8000) >> 16;
        if (span > DIST_CAP) span = DIST_CAP;
        // position uses the heading from before this sample
        heading_trig(pose_hdg, c, s);
        pose_x = move_axis(pose_x, span, diff < 0, c);
        pose_y = move_axis(pose_y, span, diff < 0, s);
        turn = gain_ang * (ul + ur);
        pose_hdg = pose_hdg - turn;
        last_left = l;
        last_right = r;
        pose.pos_x_out = pose_x;
        pose.pos_y_out = pose_y;
        pose.heading_out = pose_hdg;
        pose_q = {pose_q, pose};
    endtask

    // register write as the unit sees it, init writes also preset the pose
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] v);
        case (idx)
            CFG_INIT_X:       begin reg_init_x = v; pose_x = v; end
            CFG_INIT_Y:       begin reg_init_y = v; pose_y = v; end
            CFG_INIT_HEADING: begin reg_init_hdg = v; pose_hdg = v; end
            CFG_LIN_GAIN:     gain_lin = v;
            CFG_ANG_GAIN:     gain_ang = v;
            default:          ;
        endcase
    endtask

    task automatic check_word(input string fld, input bit [31:0] want, input bit [31:0] got);
        if (want !== got) begin
            errs++;
            if (errs <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
        end
    endtask

    // ----------------------------------------------------------------- driver
    // one pending transfer at a time; the next one may follow in the same
    // cycle its predecessor completes, so valid stays high without a gap
    always @(posedge i_clk) begin : drive_proc
        t_odo_cmd cmd;
        logic     nxt_in_vld;
        logic     nxt_cfg_vld;
        if (!i_rst_n) begin
            in_vld <= 1'b0;
            cfg_vld <= 1'b0;
        end else begin
            nxt_in_vld = in_vld;
            nxt_cfg_vld = cfg_vld;
            // sample transfer: the pose it causes is known from here on
            if (in_vld && !o_in_stall) begin
                predict_pose(in_data);
                n_samples++;
                nxt_in_vld = 1'b0;
            end
            // register transfer
            if (cfg_vld && o_cfg_ready) begin
                apply_reg(cfg_idx, cfg_wdata);
                n_writes++;
                nxt_cfg_vld = 1'b0;
            end
            // sender gaps drawn per cycle
            if (!nxt_in_vld && !nxt_cfg_vld && cmd_q.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                cmd = cmd_q.pop_front();
                if (cmd.is_reg) begin
                    nxt_cfg_vld = 1'b1;
                    cfg_idx <= cmd.idx;
                    cfg_wdata <= cmd.wdata;
                end else begin
                    nxt_in_vld = 1'b1;
                    in_data <= cmd.sample;
                end
            end
            in_vld <= nxt_in_vld;
            cfg_vld <= nxt_cfg_vld;
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin : watch_proc
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (pose_q.size() == 0) begin
                    errs++;
                    $display("%0t: pose transfer with none expected, got %h",
                             $time, o_out_data);
                end else begin
                    want = pose_q.pop_front();
                    n_poses++;
                    check_word("pos_x_out", want.pos_x_out, o_out_data.pos_x_out);
                    check_word("pos_y_out", want.pos_y_out, o_out_data.pos_y_out);
                    check_word("heading_out", want.heading_out, o_out_data.heading_out);
                end
            end
            // receiver back-pressure drawn per cycle
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------- stimulus helpers
    task automatic push_sample(input bit [31:0] l, input bit [31:0] r);
        t_odo_cmd cmd;
        gen_left = l;
        gen_right = r;
        cmd.is_reg = 1'b0;
        cmd.idx = '0;
        cmd.wdata = '0;
        cmd.sample.left_count = l;
        cmd.sample.right_count = r;
        cmd_q = {cmd_q, cmd};
    endtask

    // counts relative to the previous sample, wrapping as the encoders do
    task automatic push_delta(input int dl, input int dr);
        push_sample(gen_left + dl, gen_right + dr);
    endtask

    task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] v);
        t_odo_cmd cmd;
        cmd.is_reg = 1'b1;
        cmd.idx = idx;
        cmd.wdata = v;
        cmd.sample = '0;
        cmd_q = {cmd_q, cmd};
    endtask

    // wait until every queued transfer went through and every pose came back;
    // checked mid-cycle so the driver's updates of this cycle are visible
    task automatic settle();
        while (cmd_q.size() != 0 || in_vld || cfg_vld || pose_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // gains: zero, one, all ones, reset value, small or full random
    function automatic bit [31:0] pick_gain(bit [31:0] rst_val);
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return rst_val;
            4: return $urandom_range(4000000);
            default: return $urandom;
        endcase
    endfunction

    // pose presets: extremes of the q16.16 range or anything
    function automatic bit [31:0] pick_word();
        case ($urandom_range(4))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // --------------------------------------------------------------- sequence
    initial begin : stim_proc
        int k, dl, dr;
        reg_init_x = 32'd0;
        reg_init_y = 32'd0;
        reg_init_hdg = 32'd0;
        gain_lin = LIN_GAIN_RST;
        gain_ang = ANG_GAIN_RST;
        last_left = '0;
        last_right = '0;
        pose_x = '0;
        pose_y = '0;
        pose_hdg = '0;

        // single reset at start
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset gains, zero motion, straight, turn, extreme counts
        push_delta(0, 0);
        push_delta(1000, -1000);
        push_delta(1500, 500);
        push_delta(-700, 700);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF);
        push_sample(32'hFFFF_FFFF, 32'h0000_0000);
        push_delta(2, -2);   // counters roll over past zero
        settle();

        // huge distance from the positive x edge: clamp and saturate
        push_reg(CFG_INIT_X, 32'h7FFF_0000);
        push_reg(CFG_INIT_Y, 32'h8000_0000);
        push_reg(CFG_INIT_HEADING, 32'h2000_0000);
        push_reg(CFG_LIN_GAIN, 32'hFFFF_FFFF);
        push_reg(CFG_ANG_GAIN, 32'd0);
        push_reg(CFG_FIRST_UNUSED, $urandom);
        push_reg(CFG_LAST_UNUSED, $urandom);
        settle();
        push_delta(32'h7FFF_FFFF, 32'h8000_0001);
        push_delta(-5000, 5000);
        push_delta(32'h8000_0001, 32'h7FFF_FFFF);
        settle();

        // quadrant boundaries with full-scale turn gain
        push_reg(CFG_INIT_HEADING, 32'hDFFF_FFFF);
        push_reg(CFG_LIN_GAIN, 32'd1);
        push_reg(CFG_ANG_GAIN, 32'hFFFF_FFFF);
        push_reg(CFG_INIT_Y, 32'h7FFF_FFFF);
        push_reg(CFG_INIT_X, 32'h0000_0000);
        settle();
        push_delta(1, 0);
        push_delta(0, -1);
        push_delta(-1, -1);
        settle();
        push_reg(CFG_LIN_GAIN, 32'h0100_0000);
        push_reg(CFG_ANG_GAIN, 32'h2000_0000);
        push_reg(CFG_INIT_HEADING, 32'h6000_0000);
        settle();
        push_delta(3000, -3000);
        push_delta(1, 0);      // eighth turn per tick
        push_delta(3000, -3000);
        push_delta(1, 0);
        push_delta(3000, -3000);
        push_delta(0, 0);
        settle();

        // random rounds: fresh registers, then motion under one idle pattern
        for (int rnd = 0; rnd < 8; rnd++) begin
            push_reg(CFG_INIT_X, pick_word());
            push_reg(CFG_INIT_Y, pick_word());
            push_reg(CFG_INIT_HEADING, pick_word());
            push_reg(CFG_LIN_GAIN, pick_gain(LIN_GAIN_RST));
            push_reg(CFG_ANG_GAIN, pick_gain(ANG_GAIN_RST));
            if ($urandom_range(3) == 0)
                push_reg(CFG_IDX_W'(CFG_FIRST_UNUSED + $urandom_range(2)), $urandom);
            settle();

            case (rnd % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase

            for (int n = 0; n < 178; n++) begin
                k = $urandom_range(99);
                if (k < 45) begin
                    // driving: mirrored wheels turn opposite ways
                    dl = $urandom_range(4000);
                    dl = dl - 2000;
                    dr = $urandom_range(200);
                    dr = 100 - dr - dl;
                    push_delta(dl, dr);
                end else if (k < 70) begin
                    // any small motion, turning in place included
                    dl = $urandom_range(4000);
                    dr = $urandom_range(4000);
                    push_delta(dl - 2000, dr - 2000);
                end else if (k < 85) begin
                    dl = $urandom_range(65535);
                    dr = $urandom_range(65535);
                    push_delta(dl - 32768, dr - 32768);
                end else if (k < 95) begin
                    push_sample($urandom, $urandom);
                end else begin
                    push_sample(pick_word(), pick_word());
                end
            end
            settle();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        settle();
        repeat (60) @(posedge i_clk);

        $display("covered %0d encoder samples, %0d poses compared, %0d register writes",
                 n_samples, n_poses, n_writes);
        $display("idle patterns: none, sender gaps, receiver stalls, both; %0d mismatches",
                 errs);
        if (errs == 0 && pose_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("%0t: watchdog expired, %0d poses outstanding", $time, pose_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
